// ----- sv/rvv_pkg.sv -----
// Shared codes, constants and reset values for the relativistic velocity-Verlet step unit.
// No dependencies.
`default_nettype none
package rvv_pkg;

  typedef enum logic [1:0] {
    CFG_STEP_TIME = 2'd0,
    CFG_HALF_KICK = 2'd1,
    CFG_INV_C2    = 2'd2,
    CFG_REL_EN    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_PASS    = 2'd1,
    ST_CLAMPED = 2'd2
  } status_e;

  localparam int CFG_W = 32;

  localparam logic [31:0] STEP_TIME_RST = 32'd16777;
  localparam logic [31:0] HALF_KICK_RST = 32'd80933000;
  localparam logic [31:0] INV_C2_RST    = 32'd525410000;
  localparam logic        REL_EN_RST    = 1'b1;

  // inverse square root: 2^96 / s one quotient bit per stage, then one root bit per stage
  localparam int ISQ_DIV_STEPS  = 97;
  localparam int ISQ_ROOT_STEPS = 49;
  localparam int ISQ_LAT        = ISQ_DIV_STEPS + ISQ_ROOT_STEPS;

  localparam int MUL_LAT    = 2;
  localparam int POS_FRAC   = 24;
  localparam int Q32_FRAC   = 32;
  localparam int DTFM_SHIFT = 31;
  localparam int SQ_SHIFT   = 32;
  localparam int IC2_SHIFT  = 56;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

endpackage
`default_nettype wire

// ----- sv/rvv_mul.sv -----
// Two-stage unsigned multiplier: 32x32 partial products registered, then summed and registered.
// No dependencies.
`default_nettype none
module rvv_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  wire logic             clk_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  output logic      [AW+BW-1:0] p_o
);

  localparam int NA  = (AW + 31) / 32;
  localparam int NB  = (BW + 31) / 32;
  localparam int AXW = 32 * NA;
  localparam int BXW = 32 * NB;
  localparam int PW  = AXW + BXW;

  logic [AXW-1:0] a_ext;
  logic [BXW-1:0] b_ext;
  logic [63:0]    pp_q [NA*NB];
  logic [PW-1:0]  acc;

  assign a_ext = AXW'(a_i);
  assign b_ext = BXW'(b_i);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i*NB+j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp_q[i*NB+j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_o <= acc[AW+BW-1:0];
  end

endmodule
`default_nettype wire

// ----- sv/rvv_inv_sqrt.sv -----
// Pipelined isqrt(floor(2^96 / s)): restoring divider, then digit-by-digit square root.
// Depends on rvv_pkg for the stage counts.
`default_nettype none
module rvv_inv_sqrt #(
  parameter int SW = 34
) (
  input  wire logic                             clk_i,
  input  wire logic [SW-1:0]                    s_i,
  output logic      [rvv_pkg::ISQ_ROOT_STEPS-1:0] r_o
);

  localparam int DN  = rvv_pkg::ISQ_DIV_STEPS;
  localparam int QW  = DN;
  localparam int RN  = rvv_pkg::ISQ_ROOT_STEPS;
  localparam int RW  = RN;
  localparam int QPW = 2 * RN;
  localparam int RMW = RN + 3;

  logic [SW:0]    drem_q  [DN-1];
  logic [SW-1:0]  ds_q    [DN-1];
  logic [QW-1:0]  dq_q    [DN];
  logic [RMW-1:0] rrem_q  [RN-1];
  logic [QPW-1:0] rqs_q   [RN-1];
  logic [RW-1:0]  rroot_q [RN];

  for (genvar k = 0; k < DN; k++) begin : g_div
    logic [SW:0]   rin;
    logic [SW-1:0] sin;
    logic [QW-1:0] qin;
    logic [SW:0]   sh;
    logic          ge;
    if (k == 0) begin : g_first
      assign rin = '0;
      assign sin = s_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = drem_q[k-1];
      assign sin = ds_q[k-1];
      assign qin = dq_q[k-1];
    end
    assign sh = {rin[SW-1:0], 1'(k == 0)};
    assign ge = (sh >= {1'b0, sin});
    always_ff @(posedge clk_i) begin
      dq_q[k] <= {qin[QW-2:0], ge};
    end
    if (k < DN - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        drem_q[k] <= ge ? (sh - {1'b0, sin}) : sh;
        ds_q[k]   <= sin;
      end
    end
  end

  for (genvar j = 0; j < RN; j++) begin : g_root
    logic [RMW-1:0] rin;
    logic [QPW-1:0] qin;
    logic [RW-1:0]  root_in;
    logic [RMW-1:0] rr;
    logic [RMW-1:0] trial;
    logic           ge;
    if (j == 0) begin : g_first
      assign rin     = '0;
      assign qin     = {1'b0, dq_q[DN-1]};
      assign root_in = '0;
    end else begin : g_next
      assign rin     = rrem_q[j-1];
      assign qin     = rqs_q[j-1];
      assign root_in = rroot_q[j-1];
    end
    assign rr    = {rin[RMW-3:0], qin[QPW-1:QPW-2]};
    assign trial = RMW'({root_in, 2'b01});
    assign ge    = (rr >= trial);
    always_ff @(posedge clk_i) begin
      rroot_q[j] <= {root_in[RW-2:0], ge};
    end
    if (j < RN - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        rrem_q[j] <= ge ? (rr - trial) : rr;
        rqs_q[j]  <= {qin[QPW-3:0], 2'b00};
      end
    end
  end

  assign r_o = rroot_q[RN-1];

endmodule
`default_nettype wire

// ----- sv/relativistic_velocity_verlet_step_unit.sv -----
// Top level: one-atom-per-cycle relativistic or classical velocity-Verlet half kick and drift.
// Depends on rvv_pkg, rvv_mul and rvv_inv_sqrt.
//
// A start beat is taken in every cycle (busy_o never rises) and its result appears, marked by
// done_o for one cycle, in start order, for every mode and every atom. The path runs through
// the two inverse square root units (gamma and the renormalization), each 146 stages deep at
// one quotient or root bit per stage, plus two-stage multipliers around them. The receiver
// cannot stall; results must be taken as they come.
`default_nettype none
module relativistic_velocity_verlet_step_unit #(
  parameter int VALUE_WIDTH = 48
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic                   req_type_i,
  input  wire logic [VALUE_WIDTH-1:0] vel_x_i,
  input  wire logic [VALUE_WIDTH-1:0] vel_y_i,
  input  wire logic [VALUE_WIDTH-1:0] vel_z_i,
  input  wire logic [VALUE_WIDTH-1:0] force_x_i,
  input  wire logic [VALUE_WIDTH-1:0] force_y_i,
  input  wire logic [VALUE_WIDTH-1:0] force_z_i,
  input  wire logic [VALUE_WIDTH-1:0] pos_x_i,
  input  wire logic [VALUE_WIDTH-1:0] pos_y_i,
  input  wire logic [VALUE_WIDTH-1:0] pos_z_i,
  input  wire logic [31:0]            inv_mass_i,
  input  wire logic                   in_group_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_addr_i,
  input  wire logic [31:0]            cfg_wdata_i,
  output logic                        done_o,
  output logic      [VALUE_WIDTH-1:0] new_vel_x_o,
  output logic      [VALUE_WIDTH-1:0] new_vel_y_o,
  output logic      [VALUE_WIDTH-1:0] new_vel_z_o,
  output logic      [VALUE_WIDTH-1:0] new_pos_x_o,
  output logic      [VALUE_WIDTH-1:0] new_pos_y_o,
  output logic      [VALUE_WIDTH-1:0] new_pos_z_o,
  output logic      [1:0]             status_o
);

  localparam int W    = VALUE_WIDTH;
  localparam int SATW = W + 52;
  localparam int DTW  = 64 - rvv_pkg::DTFM_SHIFT;
  localparam int SQW  = 2 * W + 2;
  localparam int SHW  = SQW - rvv_pkg::SQ_SHIFT;
  localparam int BPW  = SHW + 32;
  localparam int SW2  = (2 * W - 52 > 34) ? 2 * W - 52 : 34;
  localparam int RW   = rvv_pkg::ISQ_ROOT_STEPS;
  localparam int ML   = rvv_pkg::MUL_LAT;

  localparam int S_GAM  = 6 + rvv_pkg::ISQ_LAT;
  localparam int S_GV   = S_GAM + ML + 1;
  localparam int S_U    = S_GV + 1;
  localparam int S_U2   = S_U + ML + 1;
  localparam int S_S    = S_U2 + ML + 1;
  localparam int S_R    = S_S + rvv_pkg::ISQ_LAT;
  localparam int S_VREL = S_R + ML + 1;
  localparam int S_VFIN = S_VREL + 1;
  localparam int S_DX   = S_VFIN + ML + 1;
  localparam int S_OUT  = S_DX + 1;

  localparam logic signed [SATW-1:0] VMAX = $signed({{(SATW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [SATW-1:0] VMIN = $signed({{(SATW-W+1){1'b1}}, {(W-1){1'b0}}});

  typedef struct packed {
    logic                req;
    logic                grp;
    logic [2:0][W-1:0]   v;
    logic [2:0][W-1:0]   x;
  } ctx_t;

  function automatic logic [W-1:0] sat_w(input logic signed [SATW-1:0] a);
    if (a > VMAX) begin
      return VMAX[W-1:0];
    end else if (a < VMIN) begin
      return VMIN[W-1:0];
    end
    return a[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_prod(input logic [SATW-1:0] m, input logic neg,
                                            input int unsigned sh);
    logic signed [SATW-1:0] t;
    t = neg ? -$signed(m) : $signed(m);
    t = t >>> sh;
    return sat_w(t);
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  // configuration
  logic [31:0] st_q, hks_q, ic2_q;
  logic        rel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= rvv_pkg::STEP_TIME_RST;
      hks_q <= rvv_pkg::HALF_KICK_RST;
      ic2_q <= rvv_pkg::INV_C2_RST;
      rel_q <= rvv_pkg::REL_EN_RST;
    end else if (cfg_we_i) begin
      case (rvv_pkg::cfg_idx_e'(cfg_addr_i))
        rvv_pkg::CFG_STEP_TIME: st_q  <= cfg_wdata_i;
        rvv_pkg::CFG_HALF_KICK: hks_q <= cfg_wdata_i;
        rvv_pkg::CFG_INV_C2:    ic2_q <= cfg_wdata_i;
        rvv_pkg::CFG_REL_EN:    rel_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // valid line and context line
  logic [S_OUT-1:0] vld_q;
  ctx_t             ctx_in;
  ctx_t             ctx_q [S_OUT];

  always_comb begin
    ctx_in.req  = req_type_i;
    ctx_in.grp  = in_group_i;
    ctx_in.v[0] = vel_x_i;
    ctx_in.v[1] = vel_y_i;
    ctx_in.v[2] = vel_z_i;
    ctx_in.x[0] = pos_x_i;
    ctx_in.x[1] = pos_y_i;
    ctx_in.x[2] = pos_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_o <= 1'b0;
    end else begin
      vld_q  <= {vld_q[S_OUT-2:0], start_i};
      done_o <= vld_q[S_OUT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q[0] <= ctx_in;
    for (int k = 1; k < S_OUT; k++) begin
      ctx_q[k] <= ctx_q[k-1];
    end
  end

  // kick factor and forces
  logic [W-1:0]   f_q    [3];
  logic [W-1:0]   f1_q   [3];
  logic [31:0]    invm_q;
  logic [DTW-1:0] dtfm_q;
  logic [2:0]     fsg2_q, fsg3_q;

  always_ff @(posedge clk_i) begin
    f_q[0] <= force_x_i;
    f_q[1] <= force_y_i;
    f_q[2] <= force_z_i;
    invm_q <= inv_mass_i;
    dtfm_q <= DTW'((64'(hks_q) * 64'(invm_q)) >> rvv_pkg::DTFM_SHIFT);
    for (int i = 0; i < 3; i++) begin
      f1_q[i]   <= f_q[i];
      fsg2_q[i] <= f1_q[i][W-1];
    end
    fsg3_q <= fsg2_q;
  end

  logic [2*W-1:0]   vsq  [3];
  logic [DTW+W-1:0] kp   [3];
  logic [RW+W-1:0]  gvp  [3];
  logic [2*W-1:0]   usq  [3];
  logic [RW+W-1:0]  vrp  [3];
  logic [32+W-1:0]  dxp  [3];
  logic [W-1:0]     u_q  [3];
  logic [W-1:0]     udl_q [S_R+2-S_U][3];
  logic [W-1:0]     vfin_q [3];
  logic [RW-1:0]    gam, rr;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rvv_mul #(.AW(W), .BW(W)) u_vsq (
      .clk_i(clk_i), .a_i(mag(ctx_q[0].v[i])), .b_i(mag(ctx_q[0].v[i])), .p_o(vsq[i])
    );
    rvv_mul #(.AW(DTW), .BW(W)) u_kick (
      .clk_i(clk_i), .a_i(dtfm_q), .b_i(mag(f1_q[i])), .p_o(kp[i])
    );
    rvv_mul #(.AW(RW), .BW(W)) u_gv (
      .clk_i(clk_i), .a_i(gam), .b_i(mag(ctx_q[S_GAM].v[i])), .p_o(gvp[i])
    );
    rvv_mul #(.AW(W), .BW(W)) u_usq (
      .clk_i(clk_i), .a_i(mag(u_q[i])), .b_i(mag(u_q[i])), .p_o(usq[i])
    );
    rvv_mul #(.AW(RW), .BW(W)) u_vr (
      .clk_i(clk_i), .a_i(rr), .b_i(mag(udl_q[S_R-S_U-1][i])), .p_o(vrp[i])
    );
    rvv_mul #(.AW(32), .BW(W)) u_dx (
      .clk_i(clk_i), .a_i(st_q), .b_i(mag(vfin_q[i])), .p_o(dxp[i])
    );
  end

  // gamma from |v|^2
  logic [SQW-1:0] v2_q;
  logic [BPW-1:0] bp, beta;
  logic [W-1:0]   kick_q [3];
  logic [W-1:0]   vcl_q  [3];
  logic [32:0]    d_q;
  logic           clamp_q;
  logic           clamp_d;

  rvv_mul #(.AW(SHW), .BW(32)) u_beta (
    .clk_i(clk_i), .a_i(v2_q[SQW-1:rvv_pkg::SQ_SHIFT]), .b_i(ic2_q), .p_o(bp)
  );

  assign beta    = bp >> rvv_pkg::IC2_SHIFT;
  assign clamp_d = |beta[BPW-1:32];

  always_ff @(posedge clk_i) begin
    v2_q <= SQW'(vsq[0]) + SQW'(vsq[1]) + SQW'(vsq[2]);
    for (int i = 0; i < 3; i++) begin
      kick_q[i] <= sat_prod(SATW'(kp[i]), fsg3_q[i], rvv_pkg::POS_FRAC);
      vcl_q[i]  <= sat_w(SATW'($signed(ctx_q[4].v[i])) + SATW'($signed(kick_q[i])));
    end
    clamp_q <= clamp_d;
    d_q     <= clamp_d ? 33'd1 : (rvv_pkg::ONE_Q32 - {1'b0, beta[31:0]});
  end

  rvv_inv_sqrt #(.SW(33)) u_gam (.clk_i(clk_i), .s_i(d_q), .r_o(gam));

  // momentum-like u and renormalization
  logic [W-1:0]   kdl_q [S_GV-4][3];
  logic [W-1:0]   gv_q  [3];
  logic [SQW-1:0] u2_q;
  logic [BPW-1:0] sp;
  logic [SW2-1:0] s_q;

  rvv_mul #(.AW(SHW), .BW(32)) u_smul (
    .clk_i(clk_i), .a_i(u2_q[SQW-1:rvv_pkg::SQ_SHIFT]), .b_i(ic2_q), .p_o(sp)
  );

  always_ff @(posedge clk_i) begin
    kdl_q[0] <= kick_q;
    for (int k = 1; k < S_GV - 4; k++) begin
      kdl_q[k] <= kdl_q[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      gv_q[i] <= sat_prod(SATW'(gvp[i]), ctx_q[S_GAM+2].v[i][W-1], rvv_pkg::Q32_FRAC);
      u_q[i]  <= sat_w(SATW'($signed(gv_q[i])) + SATW'($signed(kdl_q[S_GV-5][i])));
    end
    u2_q <= SQW'(usq[0]) + SQW'(usq[1]) + SQW'(usq[2]);
    s_q  <= SW2'(rvv_pkg::ONE_Q32) + SW2'(sp >> rvv_pkg::IC2_SHIFT);
    udl_q[0] <= u_q;
    for (int k = 1; k < S_R + 2 - S_U; k++) begin
      udl_q[k] <= udl_q[k-1];
    end
  end

  rvv_inv_sqrt #(.SW(SW2)) u_rn (.clk_i(clk_i), .s_i(s_q), .r_o(rr));

  // final velocity, status and drift
  logic [W-1:0]        vrel_q [3];
  logic [W-1:0]        vdl_q  [S_VREL-5][3];
  logic [S_VREL-7:0]   cdl_q;
  logic [W-1:0]        vfdl_q [3][3];
  logic [1:0]          stat_q;
  logic [1:0]          stdl_q [3];
  logic [W-1:0]        dx_q   [3];
  logic [W-1:0]        ovel_q [3];
  logic [W-1:0]        opos_q [3];
  logic                mv;

  assign mv = ctx_q[S_DX].grp && !ctx_q[S_DX].req;

  always_ff @(posedge clk_i) begin
    vdl_q[0] <= vcl_q;
    for (int k = 1; k < S_VREL - 5; k++) begin
      vdl_q[k] <= vdl_q[k-1];
    end
    cdl_q <= {cdl_q[S_VREL-8:0], clamp_q};
    for (int i = 0; i < 3; i++) begin
      vrel_q[i] <= sat_prod(SATW'(vrp[i]), udl_q[S_R+1-S_U][i][W-1], rvv_pkg::Q32_FRAC);
      if (!ctx_q[S_VREL].grp) begin
        vfin_q[i] <= ctx_q[S_VREL].v[i];
      end else if (rel_q) begin
        vfin_q[i] <= vrel_q[i];
      end else begin
        vfin_q[i] <= vdl_q[S_VREL-6][i];
      end
      dx_q[i] <= sat_prod(SATW'(dxp[i]), vfdl_q[1][i][W-1], rvv_pkg::POS_FRAC);
    end
    if (!ctx_q[S_VREL].grp) begin
      stat_q <= rvv_pkg::ST_PASS;
    end else if (rel_q && cdl_q[S_VREL-7]) begin
      stat_q <= rvv_pkg::ST_CLAMPED;
    end else begin
      stat_q <= rvv_pkg::ST_UPDATED;
    end
    vfdl_q[0] <= vfin_q;
    vfdl_q[1] <= vfdl_q[0];
    vfdl_q[2] <= vfdl_q[1];
    stdl_q[0] <= stat_q;
    stdl_q[1] <= stdl_q[0];
    stdl_q[2] <= stdl_q[1];
    for (int i = 0; i < 3; i++) begin
      ovel_q[i] <= vfdl_q[2][i];
      if (mv) begin
        opos_q[i] <= sat_w(SATW'($signed(ctx_q[S_DX].x[i])) + SATW'($signed(dx_q[i])));
      end else begin
        opos_q[i] <= ctx_q[S_DX].x[i];
      end
    end
    status_o <= stdl_q[2];
  end

  assign new_vel_x_o = ovel_q[0];
  assign new_vel_y_o = ovel_q[1];
  assign new_vel_z_o = ovel_q[2];
  assign new_pos_x_o = opos_q[0];
  assign new_pos_y_o = opos_q[1];
  assign new_pos_z_o = opos_q[2];

endmodule
`default_nettype wire
